/* sv/jst_pkg.sv */
// Shared types, event and error codes, and literal spelling tables for the
// JSON stream tokenizer. No dependencies.
`default_nettype none

package jst_pkg;

    // Nesting depth and result field widths
    localparam int NEST_W = 7;

    // Request kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    // Token events
    localparam logic [4:0] EV_NONE      = 5'd0;
    localparam logic [4:0] EV_OBJ_OPEN  = 5'd1;
    localparam logic [4:0] EV_OBJ_CLOSE = 5'd2;
    localparam logic [4:0] EV_ARR_OPEN  = 5'd3;
    localparam logic [4:0] EV_ARR_CLOSE = 5'd4;
    localparam logic [4:0] EV_KEY_BYTE  = 5'd5;
    localparam logic [4:0] EV_KEY_END   = 5'd6;
    localparam logic [4:0] EV_COLON     = 5'd7;
    localparam logic [4:0] EV_COMMA     = 5'd8;
    localparam logic [4:0] EV_STR_BYTE  = 5'd9;
    localparam logic [4:0] EV_STR_END   = 5'd10;
    localparam logic [4:0] EV_NUM_BYTE  = 5'd11;
    localparam logic [4:0] EV_NUM_END   = 5'd12;
    localparam logic [4:0] EV_LIT_BYTE  = 5'd13;
    localparam logic [4:0] EV_NULL      = 5'd14;
    localparam logic [4:0] EV_TRUE      = 5'd15;
    localparam logic [4:0] EV_FALSE     = 5'd16;
    localparam logic [4:0] EV_STR_OPEN  = 5'd17;
    localparam logic [4:0] EV_KEY_OPEN  = 5'd18;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_BYTE  = 2'd1;
    localparam logic [1:0] ERR_END   = 2'd2;
    localparam logic [1:0] ERR_DEPTH = 2'd3;

    // Literal kinds
    localparam logic [1:0] LIT_NULL  = 2'd0;
    localparam logic [1:0] LIT_TRUE  = 2'd1;
    localparam logic [1:0] LIT_FALSE = 2'd2;

    // Number scanner positions
    localparam logic [2:0] NUM_SIGN     = 3'd0;
    localparam logic [2:0] NUM_INT      = 3'd1;
    localparam logic [2:0] NUM_DOT      = 3'd2;
    localparam logic [2:0] NUM_FRAC     = 3'd3;
    localparam logic [2:0] NUM_EXP      = 3'd4;
    localparam logic [2:0] NUM_EXP_SIGN = 3'd5;
    localparam logic [2:0] NUM_EXP_DIG  = 3'd6;

    // Parser phase
    typedef enum logic [3:0] {
        PH_ROOT      = 4'd0,
        PH_ARR_FIRST = 4'd1,
        PH_OBJ_FIRST = 4'd2,
        PH_VALUE     = 4'd3,
        PH_KEY       = 4'd4,
        PH_IN_KEY    = 4'd5,
        PH_COLON     = 4'd6,
        PH_IN_STR    = 4'd7,
        PH_IN_NUM    = 4'd8,
        PH_IN_LIT    = 4'd9,
        PH_AFTER     = 4'd10
    } t_phase;

    // Parser state; top mirrors the kind bit on top of the nesting stack
    typedef struct packed {
        t_phase            phase;
        logic [NEST_W-1:0] nest;
        logic              top;
        logic [2:0]        npart;
        logic [1:0]        lkind;
        logic [2:0]        lpos;
        logic [1:0]        err;
    } t_state;

    // One result item
    typedef struct packed {
        logic [4:0]        ev;
        logic [7:0]        data;
        logic [NEST_W-1:0] nest;
        logic [1:0]        err;
        logic              done;
        logic              last;
    } t_result;

    localparam t_state ST_RESET = '{
        phase: PH_ROOT, nest: '0, top: 1'b0, npart: NUM_SIGN,
        lkind: LIT_NULL, lpos: 3'd0, err: ERR_NONE
    };

    // Length of each literal
    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        logic [2:0] len;
        case (kind)
            LIT_FALSE: len = 3'd5;
            default:   len = 3'd4;
        endcase
        return len;
    endfunction

    // Spelling of each literal, one character per position
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] ch;
        case ({kind, pos})
            {LIT_NULL,  3'd0}: ch = 8'h6E; // n
            {LIT_NULL,  3'd1}: ch = 8'h75; // u
            {LIT_NULL,  3'd2}: ch = 8'h6C; // l
            {LIT_NULL,  3'd3}: ch = 8'h6C; // l
            {LIT_TRUE,  3'd0}: ch = 8'h74; // t
            {LIT_TRUE,  3'd1}: ch = 8'h72; // r
            {LIT_TRUE,  3'd2}: ch = 8'h75; // u
            {LIT_TRUE,  3'd3}: ch = 8'h65; // e
            {LIT_FALSE, 3'd0}: ch = 8'h66; // f
            {LIT_FALSE, 3'd1}: ch = 8'h61; // a
            {LIT_FALSE, 3'd2}: ch = 8'h6C; // l
            {LIT_FALSE, 3'd3}: ch = 8'h73; // s
            {LIT_FALSE, 3'd4}: ch = 8'h65; // e
            default:           ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* sv/jst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module jst_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* sv/jst_step.sv */
// Next-state and result logic for one request of the tokenizer.
// Depends on jst_pkg.
`default_nettype none

module jst_step import jst_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire t_state      i_state,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_below,
    input  wire logic [6:0]  i_max_depth,
    output t_state           o_state,
    output t_result          o_first,
    output t_result          o_main,
    output logic             o_two,
    output logic             o_push,
    output logic             o_push_kind
);

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;

    function automatic logic num_complete(input logic [2:0] part);
        return (part == NUM_INT) || (part == NUM_FRAC) || (part == NUM_EXP_DIG);
    endfunction

    always_comb begin
        t_state     s;
        logic [4:0] ev;
        logic       ws;
        logic       dig;
        logic       expo;
        logic       sign;
        logic       take;
        logic       done;
        logic       do_value;
        logic       do_after;
        logic       do_close;
        logic [1:0] k;
        logic [2:0] llen;

        s        = i_state;
        ev       = EV_NONE;
        done     = 1'b0;
        take     = 1'b0;
        do_value = 1'b0;
        do_after = 1'b0;
        do_close = 1'b0;
        o_two       = 1'b0;
        o_push      = 1'b0;
        o_push_kind = 1'b0;
        ws   = (i_byte == 8'd32) || ((i_byte >= 8'd9) && (i_byte <= 8'd13));
        dig  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        expo = (i_byte == CH_E_LO) || (i_byte == CH_E_UP);
        sign = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);
        k    = (i_state.lkind == 2'd3) ? LIT_NULL : i_state.lkind;
        llen = lit_len(k);

        if (i_action == ACT_END) begin
            // End of text: flush a pending number, judge the document, restart
            if (s.err == ERR_NONE) begin
                if (s.phase == PH_IN_NUM && num_complete(s.npart)) begin
                    o_two   = 1'b1;
                    s.phase = PH_AFTER;
                end
                if (s.phase == PH_AFTER && s.nest == '0) begin
                    done = 1'b1;
                end else begin
                    s.err = ERR_END;
                end
            end
        end else if (s.err == ERR_NONE) begin
            // Dispatch on phase
            case (s.phase)
                PH_ROOT, PH_VALUE: begin
                    do_value = !ws;
                end
                PH_ARR_FIRST: begin
                    if (ws) begin
                        ev = EV_NONE;
                    end else if (i_byte == CH_RBRACK) begin
                        do_close = 1'b1;
                    end else begin
                        do_value = 1'b1;
                    end
                end
                PH_OBJ_FIRST, PH_KEY: begin
                    if (ws) begin
                        ev = EV_NONE;
                    end else if (i_byte == CH_RBRACE && s.phase == PH_OBJ_FIRST) begin
                        do_close = 1'b1;
                    end else if (i_byte == CH_QUOTE) begin
                        s.phase = PH_IN_KEY;
                        ev      = EV_KEY_OPEN;
                    end else begin
                        s.err = ERR_BYTE;
                    end
                end
                PH_IN_KEY: begin
                    if (i_byte == CH_QUOTE) begin
                        s.phase = PH_COLON;
                        ev      = EV_KEY_END;
                    end else begin
                        ev = EV_KEY_BYTE;
                    end
                end
                PH_COLON: begin
                    if (ws) begin
                        ev = EV_NONE;
                    end else if (i_byte == CH_COLON) begin
                        s.phase = PH_VALUE;
                        ev      = EV_COLON;
                    end else begin
                        s.err = ERR_BYTE;
                    end
                end
                PH_IN_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        s.phase = PH_AFTER;
                        ev      = EV_STR_END;
                    end else begin
                        ev = EV_STR_BYTE;
                    end
                end
                PH_IN_NUM: begin
                    // Advance the number grammar
                    case (s.npart)
                        NUM_SIGN: begin
                            if (dig) begin s.npart = NUM_INT; take = 1'b1; end
                        end
                        NUM_INT: begin
                            if (dig) begin
                                take = 1'b1;
                            end else if (i_byte == CH_DOT) begin
                                s.npart = NUM_DOT; take = 1'b1;
                            end else if (expo) begin
                                s.npart = NUM_EXP; take = 1'b1;
                            end
                        end
                        NUM_DOT: begin
                            if (dig) begin s.npart = NUM_FRAC; take = 1'b1; end
                        end
                        NUM_FRAC: begin
                            if (dig) begin
                                take = 1'b1;
                            end else if (expo) begin
                                s.npart = NUM_EXP; take = 1'b1;
                            end
                        end
                        NUM_EXP: begin
                            if (sign) begin
                                s.npart = NUM_EXP_SIGN; take = 1'b1;
                            end else if (dig) begin
                                s.npart = NUM_EXP_DIG; take = 1'b1;
                            end
                        end
                        NUM_EXP_SIGN: begin
                            if (dig) begin s.npart = NUM_EXP_DIG; take = 1'b1; end
                        end
                        NUM_EXP_DIG: begin
                            take = dig;
                        end
                        default: begin
                            take = 1'b0;
                        end
                    endcase
                    if (take) begin
                        ev = EV_NUM_BYTE;
                    end else if (num_complete(i_state.npart)) begin
                        // Close the number, then treat the byte as following a value
                        o_two    = 1'b1;
                        s.phase  = PH_AFTER;
                        do_after = 1'b1;
                    end else begin
                        s.err = ERR_BYTE;
                    end
                end
                PH_IN_LIT: begin
                    if ((s.lpos < llen) && (i_byte == lit_char(k, s.lpos))) begin
                        s.lpos = s.lpos + 3'd1;
                        if (s.lpos == llen) begin
                            s.phase = PH_AFTER;
                            ev      = 5'(EV_NULL + 5'(k));
                        end else begin
                            ev = EV_LIT_BYTE;
                        end
                    end else begin
                        s.err = ERR_BYTE;
                    end
                end
                default: begin
                    do_after = 1'b1;
                end
            endcase

            // Start of a value
            if (do_value) begin
                if (i_byte == CH_LBRACE || i_byte == CH_LBRACK) begin
                    if ((s.nest >= i_max_depth) || (32'(s.nest) >= 32'(STACK_DEPTH))) begin
                        s.err = ERR_DEPTH;
                    end else begin
                        o_push      = 1'b1;
                        o_push_kind = (i_byte == CH_LBRACK);
                        s.top       = o_push_kind;
                        s.nest      = s.nest + 1'b1;
                        s.phase     = o_push_kind ? PH_ARR_FIRST : PH_OBJ_FIRST;
                        ev          = o_push_kind ? EV_ARR_OPEN : EV_OBJ_OPEN;
                    end
                end else if (i_byte == CH_QUOTE) begin
                    s.phase = PH_IN_STR;
                    ev      = EV_STR_OPEN;
                end else if (sign || dig) begin
                    s.npart = dig ? NUM_INT : NUM_SIGN;
                    s.phase = PH_IN_NUM;
                    ev      = EV_NUM_BYTE;
                end else if (i_byte == CH_N || i_byte == CH_T || i_byte == CH_F) begin
                    s.lkind = (i_byte == CH_N) ? LIT_NULL :
                              (i_byte == CH_T) ? LIT_TRUE : LIT_FALSE;
                    s.lpos  = 3'd1;
                    s.phase = PH_IN_LIT;
                    ev      = EV_LIT_BYTE;
                end else begin
                    s.err = ERR_BYTE;
                end
            end

            // Byte after a complete value
            if (do_after) begin
                if (ws) begin
                    ev = EV_NONE;
                end else if (s.nest == '0) begin
                    s.err = ERR_BYTE;
                end else if (i_byte == CH_COMMA) begin
                    s.phase = s.top ? PH_VALUE : PH_KEY;
                    ev      = EV_COMMA;
                end else if ((i_byte == CH_RBRACE && !s.top) ||
                             (i_byte == CH_RBRACK && s.top)) begin
                    do_close = 1'b1;
                end else begin
                    s.err = ERR_BYTE;
                end
            end

            // Pop one nesting level; the next kind down comes from the stack memory
            if (do_close) begin
                if (s.nest == '0) begin
                    s.err = ERR_BYTE;
                end else begin
                    ev      = s.top ? EV_ARR_CLOSE : EV_OBJ_CLOSE;
                    s.nest  = s.nest - 1'b1;
                    s.top   = i_below;
                    s.phase = PH_AFTER;
                end
            end
        end

        o_first = '{ev: EV_NUM_END, data: 8'd0, nest: i_state.nest, err: ERR_NONE,
                    done: 1'b0, last: 1'b0};
        if (i_action == ACT_END) begin
            o_main  = '{ev: EV_NONE, data: 8'd0, nest: s.nest, err: s.err,
                        done: done, last: 1'b1};
            o_state = ST_RESET;
        end else begin
            o_main  = '{ev: ev, data: i_byte, nest: s.nest, err: s.err,
                        done: 1'b0, last: 1'b1};
            o_state = s;
        end
    end

endmodule

`default_nettype wire

/* sv/jst_obuf.sv */
// Four-entry result queue that takes one or two results per request and
// hands out one per cycle while i_ready is high. Depends on jst_pkg.
`default_nettype none

module jst_obuf import jst_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire logic    i_two,
    input  wire t_result i_first,
    input  wire t_result i_main,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    t_result    r_buf [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       pop;
    logic [2:0] add;

    assign o_valid = (r_cnt != 3'd0);
    assign o_room  = (r_cnt <= 3'd2);
    assign o_res   = r_buf[r_rp];
    assign pop     = o_valid && i_ready;
    assign add     = i_push ? (i_two ? 3'd2 : 3'd1) : 3'd0;
    assign n_cnt   = r_cnt + add - {2'd0, pop};

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= r_wp + add[1:0];
            r_rp  <= r_rp + {1'b0, pop};
            r_cnt <= n_cnt;
        end
    end

    // Store results in order
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (i_two) begin
                r_buf[r_wp]        <= i_first;
                r_buf[r_wp + 2'd1] <= i_main;
            end else begin
                r_buf[r_wp] <= i_main;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/json_stream_tokenizer.sv */
// Top level of the JSON stream tokenizer: request register, parser state,
// nesting stack memory and result queue. Depends on jst_pkg, jst_ram,
// jst_step and jst_obuf.
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_ready    i_action, i_text_byte
//   result    out        o_out_valid / i_out_ready  o_event_res .. o_last
//   config    in         i_cfg_we (no wait)         i_cfg_data (max_depth)
//
// One request per cycle while the result queue has room; a request giving two
// results (number end followed by the next byte) queues both. A request goes
// through the request register, then one pass of parser logic into the queue.
// The top-of-stack kind bit lives in a register and the next one down is kept
// pre-read from the stack memory, so a close never waits for a memory read.
// Reset is synchronous and clears state; no clearing pass runs. The request
// side stalls only while the result queue holds more than two results.
`default_nettype none

module json_stream_tokenizer import jst_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_action,
    input  wire logic [7:0]  i_text_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [4:0]       o_event_res,
    output logic [7:0]       o_byte_out,
    output logic [6:0]       o_nest_level,
    output logic [1:0]       o_error_code,
    output logic             o_done_res,
    output logic             o_last,
    input  wire logic        i_cfg_we,
    input  wire logic [6:0]  i_cfg_data
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic        r_in_valid;
    logic        r_action;
    logic [7:0]  r_byte;
    logic [6:0]  r_max_depth;
    t_state      r_state;
    t_state      n_state;
    t_state      step_state;
    t_result     first;
    t_result     main;
    t_result     head;
    logic        two;
    logic        push;
    logic        push_kind;
    logic        below;
    logic        room;
    logic        go;
    logic [31:0] rd_ext;
    logic [31:0] wr_ext;

    assign go         = r_in_valid && room;
    assign o_in_ready = !r_in_valid || go;
    assign n_state    = go ? step_state : r_state;

    // Hold the request until the parser takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_action <= i_action;
            r_byte   <= i_text_byte;
        end
    end

    // Depth limit register and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= 7'd64;
            r_state     <= ST_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_depth <= i_cfg_data;
            end
            r_state <= n_state;
        end
    end

    jst_step #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_step (
        .i_state     (r_state),
        .i_action    (r_action),
        .i_byte      (r_byte),
        .i_below     (below),
        .i_max_depth (r_max_depth),
        .o_state     (step_state),
        .o_first     (first),
        .o_main      (main),
        .o_two       (two),
        .o_push      (push),
        .o_push_kind (push_kind)
    );

    // Nesting stack: push writes at the current depth, the read port keeps
    // the entry just below the new top
    assign wr_ext = 32'(r_state.nest);
    assign rd_ext = 32'(n_state.nest) - 32'd2;

    jst_ram #(
        .WIDTH (1),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (go && push),
        .i_waddr (wr_ext[AW-1:0]),
        .i_wdata (push_kind),
        .i_raddr (rd_ext[AW-1:0]),
        .o_rdata (below)
    );

    jst_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_two   (two),
        .i_first (first),
        .i_main  (main),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (head)
    );

    assign o_event_res  = head.ev;
    assign o_byte_out   = head.data;
    assign o_nest_level = head.nest;
    assign o_error_code = head.err;
    assign o_done_res   = head.done;
    assign o_last       = head.last;

endmodule

`default_nettype wire
